@@ rtl/mqdo_pkg.sv @@
// ---------------------------------------------------------------------------
// mqdo_pkg
// Shared sizes, codes, types and helpers for the multi-queue drop-oldest FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

package mqdo_pkg;

  // Sizing
  localparam int NUM_QUEUES   = 256;
  localparam int QUEUE_DEPTH  = 32;
  localparam int PAYLOAD_BITS = 32;

  // Fixed field widths of the channels
  localparam int OP_W      = 2;
  localparam int QID_W     = 8;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int FILL_OUT_W = 6;

  // Derived widths
  localparam int QSEL_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MSG_AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int QS_W    = HEAD_W + FILL_W;

  localparam logic [FILL_W-1:0] DEPTH_F    = FILL_W'(QUEUE_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_M1_F = FILL_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W:0]   DEPTH_S    = (FILL_W + 1)'(QUEUE_DEPTH);
  localparam logic [HEAD_W-1:0] LAST_SLOT  = HEAD_W'(QUEUE_DEPTH - 1);

  // Request opcodes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DRAINED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_DRAIN_RD,
    S_DRAIN_WAIT
  } state_t;

  // Queue state table access
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [QSEL_W-1:0] addr;
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } qs_req_t;

  // Message store access (one address, read or write)
  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [MSG_AW-1:0]       addr;
    logic [PAYLOAD_BITS-1:0] wdata;
  } msg_req_t;

  // Next slot, wrapping at the queue depth
  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    head_inc = (h == LAST_SLOT) ? '0 : h + HEAD_W'(1);
  endfunction

  // (h + n) mod depth for h < depth, n <= depth
  function automatic logic [HEAD_W-1:0] slot_add(input logic [HEAD_W-1:0] h,
                                                 input logic [FILL_W-1:0] n);
    logic [FILL_W:0] s;
    s = (FILL_W + 1)'(h) + (FILL_W + 1)'(n);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    slot_add = HEAD_W'(s);
  endfunction

endpackage

`default_nettype wire

@@ rtl/mqdo_if.sv @@
// ---------------------------------------------------------------------------
// mqdo_if
// Request and result channels of the multi-queue drop-oldest FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

interface mqdo_cmd_if;
  import mqdo_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [QID_W-1:0]  queue_id;
  logic [WORD_W-1:0] payload;
  logic              is_empty;

  modport source (output valid, op, queue_id, payload, is_empty, input ready);
  modport sink   (input valid, op, queue_id, payload, is_empty, output ready);
endinterface

interface mqdo_rsp_if;
  import mqdo_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [FILL_OUT_W-1:0] fill;
  logic [WORD_W-1:0]     out_payload;
  logic                  last;

  modport source (output valid, status, fill, out_payload, last, input ready);
  modport sink   (input valid, status, fill, out_payload, last, output ready);
endinterface

`default_nettype wire

@@ rtl/mqdo_ram.sv @@
// ---------------------------------------------------------------------------
// mqdo_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mqdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mqdo_qstate.sv @@
// ---------------------------------------------------------------------------
// mqdo_qstate
// Per-queue head/fill table: RAM plus per-entry valid bits so that a queue
// never written since reset reads as empty.
// ---------------------------------------------------------------------------
`default_nettype none

module mqdo_qstate (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mqdo_pkg::qs_req_t          req,
  output logic [mqdo_pkg::HEAD_W-1:0]     head,
  output logic [mqdo_pkg::FILL_W-1:0]     fill
);
  import mqdo_pkg::*;

  logic [NUM_QUEUES-1:0] vld;
  logic                  rd_vld;
  logic [QS_W-1:0]       rdata;

  mqdo_ram #(.WIDTH(QS_W), .DEPTH(NUM_QUEUES)) u_ram (
    .clk   (clk),
    .we    (req.wr),
    .waddr (req.addr),
    .wdata ({req.head, req.fill}),
    .re    (req.rd),
    .raddr (req.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr) begin
        vld[req.addr] <= 1'b1;
      end
      if (req.rd) begin
        rd_vld <= vld[req.addr];
      end
    end
  end

  assign head = rd_vld ? rdata[QS_W-1:FILL_W] : '0;
  assign fill = rd_vld ? rdata[FILL_W-1:0]    : '0;

endmodule

`default_nettype wire

@@ rtl/mqdo_ctrl.sv @@
// ---------------------------------------------------------------------------
// mqdo_ctrl
// Request sequencer: table lookup, read-modify-write, drain walk and the
// result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mqdo_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mqdo_cmd_if.sink                           cmd,
  mqdo_rsp_if.source                         rsp,
  output mqdo_pkg::qs_req_t                  qs_req,
  input  wire logic [mqdo_pkg::HEAD_W-1:0]   qs_head,
  input  wire logic [mqdo_pkg::FILL_W-1:0]   qs_fill,
  output mqdo_pkg::msg_req_t                 msg_req,
  input  wire logic [mqdo_pkg::PAYLOAD_BITS-1:0] msg_rdata
);
  import mqdo_pkg::*;

  state_t state, state_next;

  // Captured request
  logic [OP_W-1:0]         op_r;
  logic [QID_W-1:0]        q_r;
  logic [PAYLOAD_BITS-1:0] word_r;
  logic                    empty_r;

  // Drain walk
  logic [HEAD_W-1:0] head_r, head_next;
  logic [FILL_W-1:0] cnt_r, cnt_next;
  logic [FILL_W-1:0] pos_r, pos_next;

  // Result register
  logic                  rsp_valid;
  logic [STATUS_W-1:0]   rsp_status;
  logic [FILL_OUT_W-1:0] rsp_fill;
  logic [WORD_W-1:0]     rsp_word;
  logic                  rsp_last;

  logic                  ld;
  logic [STATUS_W-1:0]   ld_status;
  logic [FILL_W-1:0]     ld_fill;
  logic [WORD_W-1:0]     ld_word;
  logic                  ld_last;

  logic                  accept;
  logic                  can_emit;
  logic                  q_ok;
  logic [QSEL_W-1:0]     q_sel;
  logic [MSG_AW-1:0]     base;
  logic [HEAD_W-1:0]     add_head;
  logic [FILL_W-1:0]     add_fill;
  logic [STATUS_W-1:0]   add_status;
  logic [FILL_W-1:0]     pos_inc;

  assign accept   = cmd.valid && cmd.ready;
  assign can_emit = !rsp_valid || rsp.ready;
  assign q_ok     = 32'(q_r) < 32'(NUM_QUEUES);
  assign q_sel    = QSEL_W'(q_r);
  assign base     = MSG_AW'(q_sel) * MSG_AW'(QUEUE_DEPTH);
  assign pos_inc  = pos_r + FILL_W'(1);

  // Add: make room by dropping the oldest when full
  always_comb begin
    if (qs_fill >= DEPTH_F) begin
      add_head   = head_inc(qs_head);
      add_fill   = DEPTH_M1_F;
      add_status = ST_DROPPED;
    end else begin
      add_head   = qs_head;
      add_fill   = qs_fill;
      add_status = ST_ADDED;
    end
  end

  always_comb begin
    state_next    = state;
    head_next     = head_r;
    cnt_next      = cnt_r;
    pos_next      = pos_r;
    cmd.ready     = 1'b0;
    qs_req        = '0;
    qs_req.addr   = q_sel;
    msg_req       = '0;
    msg_req.wdata = word_r;
    ld            = 1'b0;
    ld_status     = ST_NONE;
    ld_fill       = '0;
    ld_word       = '0;
    ld_last       = 1'b1;

    case (state)
      S_IDLE: begin
        cmd.ready   = 1'b1;
        qs_req.addr = QSEL_W'(cmd.queue_id);
        if (cmd.valid) begin
          qs_req.rd  = 1'b1;
          state_next = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        case (op_r)
          OP_ADD: begin
            if (can_emit) begin
              ld         = 1'b1;
              state_next = S_IDLE;
              if (!q_ok || empty_r) begin
                ld_status = ST_REJECT;
              end else begin
                ld_status     = add_status;
                ld_fill       = add_fill + FILL_W'(1);
                msg_req.we    = 1'b1;
                msg_req.addr  = base + MSG_AW'(slot_add(add_head, add_fill));
                qs_req.wr     = 1'b1;
                qs_req.head   = add_head;
                qs_req.fill   = add_fill + FILL_W'(1);
              end
            end
          end

          OP_DRAIN: begin
            if (!q_ok || qs_fill == '0) begin
              if (can_emit) begin
                ld         = 1'b1;
                ld_status  = ST_NONE;
                state_next = S_IDLE;
              end
            end else begin
              head_next   = qs_head;
              cnt_next    = (qs_fill > DEPTH_F) ? DEPTH_F : qs_fill;
              pos_next    = '0;
              qs_req.wr   = 1'b1;
              qs_req.head = slot_add(qs_head, cnt_next);
              qs_req.fill = '0;
              state_next  = S_DRAIN_RD;
            end
          end

          OP_COUNT: begin
            if (can_emit) begin
              ld         = 1'b1;
              ld_status  = ST_COUNT;
              ld_fill    = q_ok ? qs_fill : '0;
              state_next = S_IDLE;
            end
          end

          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_DRAIN_RD: begin
        msg_req.re   = 1'b1;
        msg_req.addr = base + MSG_AW'(head_r);
        state_next   = S_DRAIN_WAIT;
      end

      S_DRAIN_WAIT: begin
        if (can_emit) begin
          ld         = 1'b1;
          ld_status  = ST_DRAINED;
          ld_fill    = pos_inc;
          ld_word    = WORD_W'(msg_rdata);
          ld_last    = (pos_inc == cnt_r);
          head_next  = head_inc(head_r);
          pos_next   = pos_inc;
          state_next = ld_last ? S_IDLE : S_DRAIN_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= cmd.op;
      q_r     <= cmd.queue_id;
      word_r  <= PAYLOAD_BITS'(cmd.payload);
      empty_r <= cmd.is_empty;
    end
    head_r <= head_next;
    cnt_r  <= cnt_next;
    pos_r  <= pos_next;
    if (ld) begin
      rsp_status <= ld_status;
      rsp_fill   <= FILL_OUT_W'(ld_fill);
      rsp_word   <= ld_word;
      rsp_last   <= ld_last;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.fill        = rsp_fill;
  assign rsp.out_payload = rsp_word;
  assign rsp.last        = rsp_last;

endmodule

`default_nettype wire

@@ rtl/multi_queue_drop_oldest_fifo.sv @@
// ---------------------------------------------------------------------------
// multi_queue_drop_oldest_fifo
// Many independent circular queues sharing one message store; adds drop the
// oldest entry of a full queue, drains empty a queue word by word.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one request: op (add / drain / count), queue_id, payload and
//   is_empty. rsp returns results: status, fill, out_payload and last; last
//   marks the final result of a request.
//   Add and count: the table read is issued in the cycle the request is taken,
//   its data comes back in the next, and the single result is then loaded into
//   the output register once it can take it. The next request is taken only
//   after that, when the sequencer is back in idle.
//   Drain of n words: one table lookup, then per word a message store read,
//   then a load into the output register.
//   cmd.ready is high only while the sequencer is idle; the output register
//   lets the next request be taken while the last result still waits.
//   When rsp stalls, the result is held and the sequencer waits at its next
//   result; no result is lost or repeated.
//   Reset clears the per-queue valid bits together, so every queue reads
//   as empty at once; there is no clearing pass. The message store is not
//   cleared; only entries inside a queue's fill are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_queue_drop_oldest_fifo (
  input wire logic   clk,
  input wire logic   rst,
  mqdo_cmd_if.sink   cmd,
  mqdo_rsp_if.source rsp
);
  import mqdo_pkg::*;

  qs_req_t                 qs_req;
  logic [HEAD_W-1:0]       qs_head;
  logic [FILL_W-1:0]       qs_fill;
  msg_req_t                msg_req;
  logic [PAYLOAD_BITS-1:0] msg_rdata;

  // Sequencer: lookup, read-modify-write of queue state, drain walk
  mqdo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp       (rsp),
    .qs_req    (qs_req),
    .qs_head   (qs_head),
    .qs_fill   (qs_fill),
    .msg_req   (msg_req),
    .msg_rdata (msg_rdata)
  );

  // Per-queue head and fill
  mqdo_qstate u_qstate (
    .clk  (clk),
    .rst  (rst),
    .req  (qs_req),
    .head (qs_head),
    .fill (qs_fill)
  );

  // Message words, queue q occupies slots q*QUEUE_DEPTH .. +QUEUE_DEPTH-1
  mqdo_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_msg_ram (
    .clk   (clk),
    .we    (msg_req.we),
    .waddr (msg_req.addr),
    .wdata (msg_req.wdata),
    .re    (msg_req.re),
    .raddr (msg_req.addr),
    .rdata (msg_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/mqdo_checker.sv @@
// ---------------------------------------------------------------------------
// mqdo_checker
// Port-level checks on the result channel of the multi-queue FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

module mqdo_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                rsp_valid,
  input wire logic                                rsp_ready,
  input wire logic [mqdo_pkg::STATUS_W-1:0]       rsp_status,
  input wire logic [mqdo_pkg::FILL_OUT_W-1:0]     rsp_fill,
  input wire logic [mqdo_pkg::WORD_W-1:0]         rsp_out_payload,
  input wire logic                                rsp_last
);
  import mqdo_pkg::*;

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_fill) && $stable(rsp_out_payload) && $stable(rsp_last))
    else $error("result changed while stalled");

  // Nothing pending out of reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Only drained words come in runs; everything else is a single, wordless result
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_DRAINED |-> rsp_last && rsp_out_payload == '0)
    else $error("non-drain result not single or carries a word");

  // Rejects and empty drains report zero fill; adds and drained words never do
  a_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      (((rsp_status == ST_REJECT) || (rsp_status == ST_NONE)) ? (rsp_fill == '0) :
       ((rsp_status == ST_COUNT) || (rsp_fill != '0))))
    else $error("fill inconsistent with status");

endmodule

bind multi_queue_drop_oldest_fifo mqdo_checker u_mqdo_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_fill        (rsp.fill),
  .rsp_out_payload (rsp.out_payload),
  .rsp_last        (rsp.last)
);

`default_nettype wire
